// File: src/ubh_pkg.sv
// ----------------------------------------------------------------------------
// ubh_pkg: shared types and constants of the bootloader host engine.
// Holds the command codes, the status codes and the item types that pass
// between the front and back halves.
// ----------------------------------------------------------------------------
package ubh_pkg;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_RECEIVE = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NACK    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_LENGTH  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [7:0] ACK_BYTE  = 8'h79;
    localparam logic [7:0] NACK_BYTE = 8'h1F;
    localparam logic [7:0] SYNC_BYTE = 8'h7F;
    localparam logic [7:0] EXT_ERASE_OP = 8'h44;

    localparam logic [3:0] REQ_SYNC    = 4'd0;
    localparam logic [3:0] REQ_GET     = 4'd1;
    localparam logic [3:0] REQ_VERSION = 4'd2;
    localparam logic [3:0] REQ_ID      = 4'd3;
    localparam logic [3:0] REQ_READ    = 4'd4;
    localparam logic [3:0] REQ_GO      = 4'd5;
    localparam logic [3:0] REQ_WRITE   = 4'd6;
    localparam logic [3:0] REQ_ERASE   = 4'd7;
    localparam logic [3:0] REQ_EXTERA  = 4'd8;
    localparam logic [3:0] REQ_WPROT   = 4'd9;
    localparam logic [3:0] REQ_LAST    = 4'd12;

    // One classified input item handed from front to back.
    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  request;
        logic [31:0] target_address;
        logic [8:0]  byte_count;
        logic        erase_all;
        logic [7:0]  data_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        done_res;
        logic [2:0]  status;
        logic [3:0]  error_flags;
        logic        ext_erase_supported;
        logic [15:0] device_id;
        logic        last;
    } result_t;

    function automatic logic [7:0] opcode_of(input logic [3:0] req);
        case (req)
            4'd0:    opcode_of = 8'h7F;
            4'd1:    opcode_of = 8'h00;
            4'd2:    opcode_of = 8'h01;
            4'd3:    opcode_of = 8'h02;
            4'd4:    opcode_of = 8'h11;
            4'd5:    opcode_of = 8'h21;
            4'd6:    opcode_of = 8'h31;
            4'd7:    opcode_of = 8'h43;
            4'd8:    opcode_of = 8'h44;
            4'd9:    opcode_of = 8'h63;
            4'd10:   opcode_of = 8'h73;
            4'd11:   opcode_of = 8'h82;
            4'd12:   opcode_of = 8'h92;
            default: opcode_of = 8'h00;
        endcase
    endfunction

endpackage

// File: src/uart_bootloader_host_engine_core.sv
// Path: an item enters the front register, then the queue, then the
// sequencer's event buffer; its results leave through the output register.
// Flow: the sequencer takes a new item only after it has emitted every
// result of the last one; an item yields up to five results.
// Reset: synchronous active-low aresetn clears phase, flags and queue;
// timeouts return to 5000 and 30000 ticks.
// ----------------------------------------------------------------------------
// uart_bootloader_host_engine_core: host side of a serial bootloader link.
// Front stage, item queue and protocol sequencer with configuration regs.
// ----------------------------------------------------------------------------
module uart_bootloader_host_engine_core
    import ubh_pkg::*;
#(
    parameter int MAX_BLOCK = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [3:0]  s_request,
    input  logic [31:0] s_target_address,
    input  logic [8:0]  s_byte_count,
    input  logic        s_erase_all,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_reply_valid,
    output logic [7:0]  m_reply_byte,
    output logic        m_done_res,
    output logic [2:0]  m_status,
    output logic [3:0]  m_error_flags,
    output logic        m_ext_erase_supported,
    output logic [15:0] m_device_id,
    output logic        m_last
);

    localparam logic CFG_REPLY = 1'b0;
    localparam logic CFG_ERASE = 1'b1;

    logic [15:0] reply_to_reg;
    logic [19:0] erase_to_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_to_reg <= 16'd5000;
            erase_to_reg <= 20'd30000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_REPLY: reply_to_reg <= cfg_data[15:0];
                CFG_ERASE: erase_to_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    logic    fq_valid, fq_ready, qb_valid, qb_ready;
    item_t   fq_item, qb_item;
    result_t res;

    ubh_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_request,
        .s_target_address, .s_byte_count, .s_erase_all, .s_data_byte,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    ubh_queue u_queue (
        .aclk, .aresetn, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
    );

    ubh_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
        .aclk, .aresetn, .reply_timeout(reply_to_reg), .erase_timeout(erase_to_reg),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
        .m_valid, .m_ready, .m_res(res)
    );

    assign m_tx_valid            = res.tx_valid;
    assign m_tx_byte             = res.tx_byte;
    assign m_reply_valid         = res.reply_valid;
    assign m_reply_byte          = res.reply_byte;
    assign m_done_res            = res.done_res;
    assign m_status              = res.status;
    assign m_error_flags         = res.error_flags;
    assign m_ext_erase_supported = res.ext_erase_supported;
    assign m_device_id           = res.device_id;
    assign m_last                = res.last;

    // A status code other than ok only comes with a finished request.
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_done_res)
        else $error("status without done");

    // A transmitted byte never coincides with a forwarded reply byte.
    a_tx_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tx_valid && m_reply_valid))
        else $error("tx and reply in one result");

    // A done result is always the last of its item.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_last)
        else $error("done result not last");

endmodule

// File: src/ubh_queue.sv
// ----------------------------------------------------------------------------
// ubh_queue: short item queue between the front and back halves.
// A four-entry FIFO of register slots so either side may stall alone.
// ----------------------------------------------------------------------------
module ubh_queue
    import ubh_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_item,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_item
);

    localparam int DEPTH = 4;

    item_t      slot_reg [DEPTH];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg;

    assign wr_ready = (count_reg != 3'(DEPTH));
    assign rd_valid = (count_reg != 3'd0);
    assign rd_item  = slot_reg[rptr_reg];

    // Pointer and fill count upkeep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) begin
                slot_reg[wptr_reg] <= wr_item;
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (rd_valid && rd_ready) begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(wr_valid && wr_ready) - 3'(rd_valid && rd_ready);
        end
    end

endmodule

// File: src/ubh_front.sv
// ----------------------------------------------------------------------------
// ubh_front: input stage of the bootloader host engine.
// Registers each accepted request and forwards it to the queue.
// ----------------------------------------------------------------------------
module ubh_front
    import ubh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [3:0]  s_request,
    input  logic [31:0] s_target_address,
    input  logic [8:0]  s_byte_count,
    input  logic        s_erase_all,
    input  logic [7:0]  s_data_byte,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    logic  hold_reg;
    item_t item_reg;

    assign s_ready = !hold_reg || q_ready;
    assign q_valid = hold_reg;
    assign q_item  = item_reg;

    // Single register stage; refilled in the cycle it drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hold_reg <= 1'b1;
                item_reg <= '{command: s_command, request: s_request,
                              target_address: s_target_address,
                              byte_count: s_byte_count, erase_all: s_erase_all,
                              data_byte: s_data_byte};
            end else if (q_ready) begin
                hold_reg <= 1'b0;
            end
        end
    end

endmodule

// File: src/ubh_back.sv
// ----------------------------------------------------------------------------
// ubh_back: protocol sequencer of the bootloader host engine.
// Takes an item from the queue, works out its up to five results combinationally,
// then emits them one per cycle through an output register while it is free.
// ----------------------------------------------------------------------------
module ubh_back
    import ubh_pkg::*;
#(
    parameter int MAX_BLOCK = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] reply_timeout,
    input  logic [19:0] erase_timeout,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ACK_CMD, PH_ACK_ADDR, PH_ACK_LEN, PH_ACK_FINAL,
        PH_ACK_ERASE, PH_PAYLOAD, PH_REPLY_LEN, PH_REPLY_BODY
    } phase_t;

    typedef struct packed {
        logic       txv;
        logic [7:0] tx;
        logic       rv;
        logic [7:0] rb;
        logic       done;
        logic [2:0] st;
    } ev_t;

    localparam logic [8:0] MAXB = 9'(MAX_BLOCK);

    phase_t      phase_reg, phase_next;
    logic [3:0]  areq_reg, areq_next;
    logic [31:0] addr_reg, addr_next;
    logic [8:0]  left_reg, left_next;
    logic [7:0]  csum_reg, csum_next;
    logic [19:0] wait_reg, wait_next;
    logic        ext_reg, ext_next;
    logic [3:0]  err_reg, err_next;
    logic [15:0] id_reg, id_next;
    logic [8:0]  ridx_reg, ridx_next;

    // Event buffer of the item being emitted.
    ev_t        ev_reg [5];
    ev_t        ev_next [5];
    logic [2:0] n_next, n_reg, pos_reg;
    logic       busy_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    // Emission drains events; a new item is taken whenever the buffer is empty,
    // whether or not the output register is free.
    logic take;
    logic out_free;
    assign out_free = !out_valid_reg || m_ready;
    assign q_ready  = !busy_reg;
    assign take     = q_valid && !busy_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

    // Next-state computation for one item, in the model's order.
    always_comb begin
        logic [3:0]  req;
        logic        need_len;
        logic [7:0]  b, n, a3, a2, a1, a0, op;
        logic [19:0] limit;
        logic [2:0]  k;
        phase_next = phase_reg; areq_next = areq_reg; addr_next = addr_reg;
        left_next = left_reg; csum_next = csum_reg; wait_next = wait_reg;
        ext_next = ext_reg; err_next = err_reg; id_next = id_reg; ridx_next = ridx_reg;
        for (int i = 0; i < 5; i++) ev_next[i] = '0;
        k = 3'd0;
        b = q_item.data_byte;
        req = q_item.request;
        need_len = 1'b0;
        n = 8'd0; op = 8'd0; limit = 20'd0;
        a3 = addr_reg[31:24]; a2 = addr_reg[23:16]; a1 = addr_reg[15:8]; a0 = addr_reg[7:0];
        case (q_item.command)
            CMD_START: begin
                if (phase_reg == PH_IDLE && req <= REQ_LAST) begin
                    addr_next = q_item.target_address;
                    left_next = q_item.byte_count;
                    csum_next = 8'd0; ridx_next = 9'd0; wait_next = 20'd0;
                    if (req == REQ_ERASE && ext_reg) req = REQ_EXTERA;
                    if (req == REQ_ERASE && q_item.erase_all) left_next = 9'd0;
                    areq_next = req;
                    need_len = req == REQ_READ || req == REQ_WRITE || req == REQ_WPROT
                        || (req == REQ_ERASE && !q_item.erase_all);
                    op = opcode_of(req);
                    if (need_len && (q_item.byte_count == 9'd0 || q_item.byte_count > MAXB)) begin
                        err_next = err_reg | 4'b0100;
                        phase_next = PH_IDLE;
                        ev_next[0] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_LENGTH};
                        k = 3'd1;
                    end else if (req == REQ_SYNC) begin
                        ev_next[0] = '{txv:1, tx:SYNC_BYTE, rv:0, rb:0, done:0, st:0};
                        k = 3'd1;
                        phase_next = PH_ACK_FINAL;
                    end else begin
                        ev_next[0] = '{txv:1, tx:op, rv:0, rb:0, done:0, st:0};
                        ev_next[1] = '{txv:1, tx:~op, rv:0, rb:0, done:0, st:0};
                        k = 3'd2;
                        phase_next = PH_ACK_CMD;
                    end
                end
            end
            CMD_PAYLOAD: begin
                if (phase_reg == PH_PAYLOAD) begin
                    ev_next[0] = '{txv:1, tx:b, rv:0, rb:0, done:0, st:0};
                    k = 3'd1;
                    csum_next = csum_reg ^ b;
                    left_next = left_reg - 9'd1;
                    if (left_next == 9'd0) begin
                        ev_next[1] = '{txv:1, tx:csum_next, rv:0, rb:0, done:0, st:0};
                        k = 3'd2;
                        phase_next = PH_ACK_FINAL; wait_next = 20'd0;
                    end
                end
            end
            CMD_RECEIVE: begin
                if (phase_reg inside {PH_ACK_CMD, PH_ACK_ADDR, PH_ACK_LEN,
                                      PH_ACK_FINAL, PH_ACK_ERASE}) begin
                    wait_next = 20'd0;
                    if (b == ACK_BYTE) begin
                        n = 8'(left_reg - 9'd1);
                        case (phase_reg)
                            PH_ACK_CMD: begin
                                if (areq_reg == REQ_GET || areq_reg == REQ_ID) begin
                                    phase_next = PH_REPLY_LEN;
                                end else if (areq_reg == REQ_VERSION) begin
                                    left_next = 9'd3; ridx_next = 9'd0;
                                    phase_next = PH_REPLY_BODY;
                                end else if (areq_reg >= REQ_READ && areq_reg <= REQ_WRITE) begin
                                    ev_next[0] = '{txv:1, tx:a3, rv:0, rb:0, done:0, st:0};
                                    ev_next[1] = '{txv:1, tx:a2, rv:0, rb:0, done:0, st:0};
                                    ev_next[2] = '{txv:1, tx:a1, rv:0, rb:0, done:0, st:0};
                                    ev_next[3] = '{txv:1, tx:a0, rv:0, rb:0, done:0, st:0};
                                    ev_next[4] = '{txv:1, tx:a3^a2^a1^a0, rv:0, rb:0,
                                                   done:0, st:0};
                                    k = 3'd5;
                                    phase_next = PH_ACK_ADDR;
                                end else if (areq_reg == REQ_ERASE && left_reg == 9'd0) begin
                                    ev_next[0] = '{txv:1, tx:8'hFF, rv:0, rb:0, done:0, st:0};
                                    ev_next[1] = '{txv:1, tx:8'h00, rv:0, rb:0, done:0, st:0};
                                    k = 3'd2;
                                    phase_next = PH_ACK_ERASE;
                                end else if (areq_reg == REQ_ERASE || areq_reg == REQ_WPROT) begin
                                    ev_next[0] = '{txv:1, tx:n, rv:0, rb:0, done:0, st:0};
                                    k = 3'd1;
                                    csum_next = n;
                                    phase_next = PH_PAYLOAD;
                                end else if (areq_reg == REQ_EXTERA) begin
                                    ev_next[0] = '{txv:1, tx:8'hFF, rv:0, rb:0, done:0, st:0};
                                    ev_next[1] = '{txv:1, tx:8'hFF, rv:0, rb:0, done:0, st:0};
                                    ev_next[2] = '{txv:1, tx:8'h00, rv:0, rb:0, done:0, st:0};
                                    k = 3'd3;
                                    phase_next = PH_ACK_ERASE;
                                end else begin
                                    phase_next = PH_ACK_FINAL;
                                end
                            end
                            PH_ACK_ADDR: begin
                                if (areq_reg == REQ_READ) begin
                                    ev_next[0] = '{txv:1, tx:n, rv:0, rb:0, done:0, st:0};
                                    ev_next[1] = '{txv:1, tx:~n, rv:0, rb:0, done:0, st:0};
                                    k = 3'd2;
                                    phase_next = PH_ACK_LEN;
                                end else if (areq_reg == REQ_WRITE) begin
                                    ev_next[0] = '{txv:1, tx:n, rv:0, rb:0, done:0, st:0};
                                    k = 3'd1;
                                    csum_next = n;
                                    phase_next = PH_PAYLOAD;
                                end else begin
                                    phase_next = PH_IDLE;
                                    ev_next[0] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_OK};
                                    k = 3'd1;
                                end
                            end
                            PH_ACK_LEN: begin
                                ridx_next = 9'd0;
                                phase_next = PH_REPLY_BODY;
                            end
                            default: begin
                                phase_next = PH_IDLE;
                                ev_next[0] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_OK};
                                k = 3'd1;
                            end
                        endcase
                    end else if (b == NACK_BYTE) begin
                        err_next = err_reg | 4'b0001;
                        phase_next = PH_IDLE;
                        ev_next[0] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_NACK};
                        k = 3'd1;
                    end else begin
                        err_next = err_reg | 4'b1000;
                        phase_next = PH_IDLE;
                        ev_next[0] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_UNKNOWN};
                        k = 3'd1;
                    end
                end else if (phase_reg == PH_REPLY_LEN) begin
                    ev_next[0] = '{txv:0, tx:0, rv:1, rb:b, done:0, st:0};
                    k = 3'd1;
                    left_next = {1'b0, b} + 9'd1;
                    ridx_next = 9'd0; wait_next = 20'd0;
                    phase_next = PH_REPLY_BODY;
                end else if (phase_reg == PH_REPLY_BODY) begin
                    ev_next[0] = '{txv:0, tx:0, rv:1, rb:b, done:0, st:0};
                    k = 3'd1;
                    if (areq_reg == REQ_GET && ridx_reg != 9'd0 && b == EXT_ERASE_OP)
                        ext_next = 1'b1;
                    if (areq_reg == REQ_ID) begin
                        if (ridx_reg == 9'd0) id_next = {b, id_reg[7:0]};
                        else if (ridx_reg == 9'd1) id_next = {id_reg[15:8], b};
                    end
                    ridx_next = ridx_reg + 9'd1;
                    left_next = left_reg - 9'd1;
                    wait_next = 20'd0;
                    if (left_next == 9'd0) begin
                        if (areq_reg == REQ_READ) begin
                            phase_next = PH_IDLE;
                            ev_next[1] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_OK};
                            k = 3'd2;
                        end else begin
                            phase_next = PH_ACK_FINAL;
                        end
                    end
                end
            end
            default: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_PAYLOAD) begin
                    limit = (phase_reg == PH_ACK_ERASE) ? erase_timeout
                                                        : {4'd0, reply_timeout};
                    if ({1'b0, wait_reg} + 21'd1 >= {1'b0, limit}) begin
                        err_next = err_reg | 4'b0010;
                        phase_next = PH_IDLE; wait_next = 20'd0;
                        ev_next[0] = '{txv:0, tx:0, rv:0, rb:0, done:1, st:ST_TIMEOUT};
                        k = 3'd1;
                    end else begin
                        wait_next = wait_reg + 20'd1;
                    end
                end
            end
        endcase
        n_next = k;
    end

    // State update and event emission.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            areq_reg <= '0; addr_reg <= '0; left_reg <= '0; csum_reg <= '0;
            wait_reg <= '0; ext_reg <= 1'b0; err_reg <= '0; id_reg <= '0;
            ridx_reg <= '0;
            busy_reg <= 1'b0; n_reg <= '0; pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // The output register is loaded by an emission, else freed on accept.
            if (!take && busy_reg && out_free) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (take) begin
                phase_reg <= phase_next; areq_reg <= areq_next; addr_reg <= addr_next;
                left_reg <= left_next; csum_reg <= csum_next; wait_reg <= wait_next;
                ext_reg <= ext_next; err_reg <= err_next; id_reg <= id_next;
                ridx_reg <= ridx_next;
                for (int i = 0; i < 5; i++) ev_reg[i] <= ev_next[i];
                n_reg <= n_next; pos_reg <= 3'd0;
                busy_reg <= (n_next != 3'd0);
            end else if (busy_reg && out_free) begin
                out_reg <= '{tx_valid: ev_reg[pos_reg].txv, tx_byte: ev_reg[pos_reg].tx,
                             reply_valid: ev_reg[pos_reg].rv,
                             reply_byte: ev_reg[pos_reg].rb,
                             done_res: ev_reg[pos_reg].done, status: ev_reg[pos_reg].st,
                             error_flags: err_reg, ext_erase_supported: ext_reg,
                             device_id: id_reg, last: (pos_reg + 3'd1 == n_reg)};
                pos_reg <= pos_reg + 3'd1;
                if (pos_reg + 3'd1 == n_reg) busy_reg <= 1'b0;
            end
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bootloader host engine core.
// A driver feeds requests from a queue and a monitor compares every result
// with a cycle-free model of the protocol sequencer kept in this module.
// ----------------------------------------------------------------------------
module tb;
    import ubh_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // Phases of the protocol sequencer, as the model walks them.
    typedef enum logic [3:0] {
        P_IDLE, P_ACK_CMD, P_ACK_ADDR, P_ACK_LEN, P_ACK_FINAL,
        P_ACK_ERASE, P_PAYLOAD, P_REPLY_LEN, P_REPLY_BODY
    } host_phase_t;

    localparam logic [3:0] REQ_WUNPROT = 4'd10;
    localparam logic [3:0] REQ_RPROT   = 4'd11;
    localparam logic [0:0] REG_REPLY_TO = 1'b0;
    localparam logic [0:0] REG_ERASE_TO = 1'b1;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [3:0]  s_request;
    logic [31:0] s_target_address;
    logic [8:0]  s_byte_count;
    logic        s_erase_all;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_reply_valid;
    logic [7:0]  m_reply_byte;
    logic        m_done_res;
    logic [2:0]  m_status;
    logic [3:0]  m_error_flags;
    logic        m_ext_erase_supported;
    logic [15:0] m_device_id;
    logic        m_last;

    uart_bootloader_host_engine_core i_dut (.*);

    // Clock.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Model state.
    host_phase_t m_phase;
    logic [3:0]  m_req;
    logic [31:0] m_addr;
    logic [8:0]  m_left;
    logic [7:0]  m_csum;
    logic [19:0] m_wait;
    logic        m_ext;
    logic [3:0]  m_sticky;
    logic [15:0] m_id;
    logic [8:0]  m_ridx;
    logic [15:0] m_reply_to;
    logic [19:0] m_erase_to;

    item_t   pending_requests[$];
    result_t expected_results[$];
    result_t step_out[$];

    int mismatches;
    int results_seen;
    int requests_sent;
    int cycle_count;
    bit hold_off;
    int hold_cycles;

    function automatic void emit(logic txv, logic [7:0] tx, logic rv, logic [7:0] rb,
                                 logic dn, logic [2:0] st);
        result_t r;
        r = '0;
        r.tx_valid = txv; r.tx_byte = tx; r.reply_valid = rv; r.reply_byte = rb;
        r.done_res = dn; r.status = st;
        step_out.push_back(r);
    endfunction

    function automatic void send_byte(logic [7:0] b);
        emit(1'b1, b, 1'b0, 8'h00, 1'b0, ST_OK);
    endfunction

    function automatic void close_request(logic [2:0] st, logic [3:0] flag);
        m_sticky |= flag;
        m_phase = P_IDLE;
        m_wait = '0;
        emit(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, st);
    endfunction

    function automatic void go_phase(host_phase_t p);
        m_phase = p;
        m_wait = '0;
    endfunction

    function automatic logic [7:0] req_opcode(logic [3:0] r);
        logic [7:0] op;
        case (r)
            REQ_SYNC:    op = 8'h7F;
            REQ_GET:     op = 8'h00;
            REQ_VERSION: op = 8'h01;
            REQ_ID:      op = 8'h02;
            REQ_READ:    op = 8'h11;
            REQ_GO:      op = 8'h21;
            REQ_WRITE:   op = 8'h31;
            REQ_ERASE:   op = 8'h43;
            REQ_EXTERA:  op = 8'h44;
            REQ_WPROT:   op = 8'h63;
            REQ_WUNPROT: op = 8'h73;
            REQ_RPROT:   op = 8'h82;
            default:     op = 8'h92;
        endcase
        return op;
    endfunction

    function automatic void start_run();
        logic [7:0] n;
        n = 8'(m_left - 9'd1);
        send_byte(n);
        m_csum = n;
        go_phase(P_PAYLOAD);
    endfunction

    // Acknowledge received: advance to the next frame of the request.
    function automatic void take_ack();
        logic [7:0] n;
        case (m_phase)
            P_ACK_CMD: begin
                if (m_req == REQ_GET || m_req == REQ_ID) begin
                    go_phase(P_REPLY_LEN);
                end else if (m_req == REQ_VERSION) begin
                    m_left = 9'd3; m_ridx = '0; go_phase(P_REPLY_BODY);
                end else if (m_req >= REQ_READ && m_req <= REQ_WRITE) begin
                    send_byte(m_addr[31:24]); send_byte(m_addr[23:16]);
                    send_byte(m_addr[15:8]); send_byte(m_addr[7:0]);
                    send_byte(m_addr[31:24] ^ m_addr[23:16] ^ m_addr[15:8] ^ m_addr[7:0]);
                    go_phase(P_ACK_ADDR);
                end else if (m_req == REQ_ERASE && m_left == 0) begin
                    send_byte(8'hFF); send_byte(8'h00); go_phase(P_ACK_ERASE);
                end else if (m_req == REQ_ERASE || m_req == REQ_WPROT) begin
                    start_run();
                end else if (m_req == REQ_EXTERA) begin
                    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00);
                    go_phase(P_ACK_ERASE);
                end else begin
                    go_phase(P_ACK_FINAL);
                end
            end
            P_ACK_ADDR: begin
                if (m_req == REQ_READ) begin
                    n = 8'(m_left - 9'd1);
                    send_byte(n); send_byte(~n);
                    go_phase(P_ACK_LEN);
                end else if (m_req == REQ_WRITE) begin
                    start_run();
                end else begin
                    close_request(ST_OK, 4'b0000);
                end
            end
            P_ACK_LEN: begin
                m_ridx = '0;
                go_phase(P_REPLY_BODY);
            end
            default: close_request(ST_OK, 4'b0000);
        endcase
    endfunction

    // Work out the results of one accepted request.
    function automatic void predict_request(item_t it);
        logic [3:0] r;
        logic       need_len;
        logic [19:0] lim;
        step_out.delete();
        case (it.command)
            CMD_START: begin
                r = it.request;
                if (m_phase == P_IDLE && r <= REQ_LAST) begin
                    m_addr = it.target_address;
                    m_left = it.byte_count;
                    m_csum = '0; m_ridx = '0; m_wait = '0;
                    if (r == REQ_ERASE && m_ext) r = REQ_EXTERA;
                    if (r == REQ_ERASE && it.erase_all) m_left = '0;
                    m_req = r;
                    need_len = (r == REQ_READ || r == REQ_WRITE || r == REQ_WPROT ||
                                (r == REQ_ERASE && !it.erase_all));
                    if (need_len && (m_left == 0 || m_left > 9'd256)) begin
                        close_request(ST_LENGTH, 4'b0100);
                    end else if (r == REQ_SYNC) begin
                        send_byte(SYNC_BYTE); go_phase(P_ACK_FINAL);
                    end else begin
                        send_byte(req_opcode(r)); send_byte(~req_opcode(r));
                        go_phase(P_ACK_CMD);
                    end
                end
            end
            CMD_PAYLOAD: begin
                if (m_phase == P_PAYLOAD) begin
                    send_byte(it.data_byte);
                    m_csum ^= it.data_byte;
                    m_left = m_left - 9'd1;
                    if (m_left == 0) begin
                        send_byte(m_csum); go_phase(P_ACK_FINAL);
                    end
                end
            end
            CMD_RECEIVE: begin
                if (m_phase >= P_ACK_CMD && m_phase <= P_ACK_ERASE) begin
                    if (it.data_byte == ACK_BYTE) take_ack();
                    else if (it.data_byte == NACK_BYTE) close_request(ST_NACK, 4'b0001);
                    else close_request(ST_UNKNOWN, 4'b1000);
                end else if (m_phase == P_REPLY_LEN) begin
                    emit(1'b0, 8'h00, 1'b1, it.data_byte, 1'b0, ST_OK);
                    m_left = 9'(it.data_byte) + 9'd1;
                    m_ridx = '0;
                    go_phase(P_REPLY_BODY);
                end else if (m_phase == P_REPLY_BODY) begin
                    emit(1'b0, 8'h00, 1'b1, it.data_byte, 1'b0, ST_OK);
                    if (m_req == REQ_GET && m_ridx != 0 && it.data_byte == EXT_ERASE_OP)
                        m_ext = 1'b1;
                    if (m_req == REQ_ID) begin
                        if (m_ridx == 0) m_id[15:8] = it.data_byte;
                        else if (m_ridx == 1) m_id[7:0] = it.data_byte;
                    end
                    m_ridx = m_ridx + 9'd1;
                    m_left = m_left - 9'd1;
                    m_wait = '0;
                    if (m_left == 0) begin
                        if (m_req == REQ_READ) close_request(ST_OK, 4'b0000);
                        else go_phase(P_ACK_FINAL);
                    end
                end
            end
            default: begin
                if (m_phase != P_IDLE && m_phase != P_PAYLOAD) begin
                    lim = (m_phase == P_ACK_ERASE) ? m_erase_to : 20'(m_reply_to);
                    if (21'(m_wait) + 21'd1 >= 21'(lim)) close_request(ST_TIMEOUT, 4'b0010);
                    else m_wait = m_wait + 20'd1;
                end
            end
        endcase
        foreach (step_out[k]) begin
            step_out[k].error_flags = m_sticky;
            step_out[k].ext_erase_supported = m_ext;
            step_out[k].device_id = m_id;
            step_out[k].last = (k == step_out.size() - 1);
            expected_results.push_back(step_out[k]);
        end
    endfunction

    // Request builders for the stimulus queue.
    function automatic item_t mk(logic [1:0] c, logic [3:0] r, logic [31:0] a,
                                 logic [8:0] n, logic ea, logic [7:0] d);
        item_t it;
        it.command = c; it.request = r; it.target_address = a;
        it.byte_count = n; it.erase_all = ea; it.data_byte = d;
        return it;
    endfunction

    function automatic void push_start(logic [3:0] r, logic [31:0] a, logic [8:0] n,
                                       logic ea);
        pending_requests.push_back(mk(CMD_START, r, a, n, ea, 8'($urandom)));
    endfunction

    function automatic void push_rx(logic [7:0] d);
        pending_requests.push_back(mk(CMD_RECEIVE, 4'($urandom), $urandom,
                                      9'($urandom), 1'($urandom), d));
    endfunction

    function automatic void push_payload(logic [7:0] d);
        pending_requests.push_back(mk(CMD_PAYLOAD, 4'($urandom), $urandom,
                                      9'($urandom), 1'($urandom), d));
    endfunction

    function automatic void push_tick();
        pending_requests.push_back(mk(CMD_TICK, 4'($urandom), $urandom,
                                      9'($urandom), 1'($urandom), 8'($urandom)));
    endfunction

    // Acknowledge byte, occasionally replaced by a NACK or a stray value.
    function automatic logic [7:0] ack_or_fault();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return NACK_BYTE;
        if (p == 1) return 8'($urandom);
        return ACK_BYTE;
    endfunction

    // One request sequence with random content; it may carry a bad length, a run of ticks or faulted acknowledges.
    function automatic void push_sequence();
        logic [3:0] r;
        logic [8:0] n;
        int k;
        int len;
        r = 4'($urandom_range(0, 12));
        n = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 6));
        push_start(r, $urandom, n, 1'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            for (k = 0; k < 5; k++) push_tick();
            return;
        end
        push_rx(ack_or_fault());
        case (r)
            REQ_GET, REQ_ID: begin
                len = $urandom_range(0, 4);
                push_rx(8'(len));
                for (k = 0; k <= len; k++)
                    push_rx(($urandom_range(0, 2) == 0) ? EXT_ERASE_OP : 8'($urandom));
                push_rx(ack_or_fault());
            end
            REQ_VERSION: begin
                for (k = 0; k < 3; k++) push_rx(8'($urandom));
                push_rx(ack_or_fault());
            end
            REQ_READ: begin
                push_rx(ack_or_fault()); push_rx(ack_or_fault());
                for (k = 0; k < n && k < 6; k++) push_rx(8'($urandom));
            end
            REQ_WRITE, REQ_ERASE, REQ_WPROT: begin
                if (r == REQ_WRITE) push_rx(ack_or_fault());
                for (k = 0; k < n && k < 6; k++) push_payload(8'($urandom));
                push_rx(ack_or_fault());
            end
            default: push_rx(ack_or_fault());
        endcase
    endfunction

    // Configuration write task used while the block is idle.
    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_REPLY_TO) m_reply_to = val[15:0];
        else m_erase_to = val[19:0];
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Driver: presents queued requests with random gaps.
    int gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap <= 0;
        end else if (s_valid && !s_ready) begin
            // hold the current request
        end else if (gap > 0) begin
            s_valid <= 1'b0;
            gap <= gap - 1;
        end else if (pending_requests.size() != 0) begin
            item_t it;
            it = pending_requests.pop_front();
            s_valid <= 1'b1;
            s_command <= it.command; s_request <= it.request;
            s_target_address <= it.target_address; s_byte_count <= it.byte_count;
            s_erase_all <= it.erase_all; s_data_byte <= it.data_byte;
            gap <= ($urandom_range(0, 3) != 0) ? 0 :
                   (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 3));
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Model update on every accepted request.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_request(item_t'{s_command, s_request, s_target_address,
                                    s_byte_count, s_erase_all, s_data_byte});
            requests_sent++;
        end
    end

    // Receiver stall pattern, with one long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 300) hold_off <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) ||
                       ($urandom_range(0, 1) == 0 && cycle_count[9]);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_t got;
            result_t want;
            got = result_t'{m_tx_valid, m_tx_byte, m_reply_valid, m_reply_byte,
                            m_done_res, m_status, m_error_flags,
                            m_ext_erase_supported, m_device_id, m_last};
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %h, actual %h", want, got);
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        int k;
        mismatches = 0; results_seen = 0; requests_sent = 0; cycle_count = 0;
        hold_off = 1'b0; hold_cycles = 0;
        m_phase = P_IDLE; m_req = '0; m_addr = '0; m_left = '0; m_csum = '0;
        m_wait = '0; m_ext = 1'b0; m_sticky = '0; m_id = '0; m_ridx = '0;
        m_reply_to = 16'd5000; m_erase_to = 20'd30000;
        aresetn = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_command = '0; s_request = '0; s_target_address = '0;
        s_byte_count = '0; s_erase_all = 1'b0; s_data_byte = '0; m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: stray input, bad lengths, short ID reply, erase paths.
        write_reg(REG_REPLY_TO, 32'd1);
        write_reg(REG_ERASE_TO, 32'd3);
        push_tick(); push_rx(ACK_BYTE); push_payload(8'hFF);
        push_start(4'd13, '1, 9'd1, 1'b0);
        push_start(REQ_READ, 32'h0, 9'd0, 1'b0);
        push_start(REQ_WRITE, 32'h0, 9'd257, 1'b0);
        push_start(REQ_WPROT, 32'h0, 9'd511, 1'b0);
        push_start(REQ_ID, '1, 9'd0, 1'b0);
        push_start(REQ_SYNC, 32'h0, 9'd0, 1'b0);
        push_rx(ACK_BYTE); push_rx(8'h00); push_rx(8'hA5); push_rx(ACK_BYTE);
        push_start(REQ_ERASE, 32'h0, 9'd0, 1'b1); push_rx(ACK_BYTE);
        push_tick(); push_tick(); push_tick();
        push_start(REQ_GO, 32'hFFFF_FFFF, 9'd256, 1'b0); push_tick();
        push_start(REQ_GET, 32'h0, 9'd0, 1'b0); push_rx(ACK_BYTE); push_rx(8'h01);
        push_rx(8'h31); push_rx(EXT_ERASE_OP); push_rx(ACK_BYTE);
        push_start(REQ_ERASE, 32'h0, 9'd3, 1'b0); push_rx(ACK_BYTE); push_rx(ACK_BYTE);
        drain();

        // Block write under a long receiver hold-off, so the input stalls.
        write_reg(REG_REPLY_TO, 32'd65535);
        write_reg(REG_ERASE_TO, 32'd1048575);
        hold_cycles = 0; hold_off = 1'b1;
        push_start(REQ_WRITE, 32'h8000_0001, 9'd24, 1'b0);
        push_rx(ACK_BYTE); push_rx(ACK_BYTE);
        for (k = 0; k < 24; k++) push_payload(8'($urandom));
        push_rx(NACK_BYTE);
        drain();

        // Random requests over a few timeout settings, including zero.
        for (k = 0; k < 4; k++) begin
            write_reg(REG_REPLY_TO, (k == 0) ? 32'd0 : 32'($urandom_range(1, 6)));
            write_reg(REG_ERASE_TO, (k == 1) ? 32'd0 : 32'($urandom_range(1, 8)));
            repeat (3) push_sequence();
            repeat (3) begin
                pending_requests.push_back(mk(2'($urandom), 4'($urandom), $urandom,
                                              9'($urandom), 1'($urandom), 8'($urandom)));
            end
            drain();
        end

        $display("Run covered %0d requests and %0d results, all request types,",
                 requests_sent, results_seen);
        $display("faulted acknowledges, timeouts and a long receiver hold-off.");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
src/ubh_pkg.sv
src/ubh_queue.sv
src/ubh_front.sv
src/ubh_back.sv
src/uart_bootloader_host_engine_core.sv
tb/tb.sv
